FILE: src/frsa_pkg.sv
// ----------------------------------------------------------------------------
// frsa_pkg: shared types and constants of the ring slot allocator
// Result codes, field widths and the structs that pass between the
// allocator, the queue cells and the top level.
// ----------------------------------------------------------------------------
package frsa_pkg;

	localparam int unsigned MAX_SLOTS = 16;  // queue depth and largest ring size
	localparam int unsigned FENCE_W = 64;
	localparam int unsigned CNT_W = 5;      // ring size, pointers and queue count
	localparam int unsigned KIND_W = 2;
	localparam int unsigned IDX_W = 4;      // width of the reported slot index
	localparam int unsigned RESULT_CAP = 16;
	localparam int unsigned N_W = 5;        // holds 0..RESULT_CAP

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FULL  = 2'd1,
		KIND_FREED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_RETIRE = 2'b10
	} state_t;

	typedef struct packed {
		logic             ok;
		logic [CNT_W-1:0] slot;
	} grant_t;

	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] slot;
	} retire_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

FILE: src/frsa_cell.sv
// ----------------------------------------------------------------------------
// frsa_cell: one entry of the in-flight frame queue
// Holds a frame's fence and slot. On a shift it takes its upper neighbor's
// entry, on a load it takes the newly pushed frame.
// ----------------------------------------------------------------------------
module frsa_cell (
	input  logic                            clk,
	input  frsa_pkg::cell_ctl_t             ctl,
	input  logic [frsa_pkg::FENCE_W-1:0]    load_fence,
	input  logic [frsa_pkg::CNT_W-1:0]      load_slot,
	input  logic [frsa_pkg::FENCE_W-1:0]    next_fence,
	input  logic [frsa_pkg::CNT_W-1:0]      next_slot,
	output logic [frsa_pkg::FENCE_W-1:0]    fence,
	output logic [frsa_pkg::CNT_W-1:0]      slot
);
	import frsa_pkg::*;

	logic [FENCE_W-1:0] fence_q;
	logic [CNT_W-1:0]   slot_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			fence_q <= next_fence;
			slot_q  <= next_slot;
		end else if (ctl.load) begin
			fence_q <= load_fence;
			slot_q  <= load_slot;
		end
	end

	assign fence = fence_q;
	assign slot  = slot_q;

endmodule

FILE: src/frsa_alloc.sv
// ----------------------------------------------------------------------------
// frsa_alloc: ring pointer bookkeeping
// Keeps ring head, ring tail and the used-slot count, decides whether a push
// can be granted a slot and which one, and frees slots as frames retire.
// ----------------------------------------------------------------------------
module frsa_alloc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clr,
	input  logic [frsa_pkg::CNT_W-1:0]  size,
	input  logic [frsa_pkg::CNT_W-1:0]  queue_count,
	input  logic                        push,
	input  frsa_pkg::retire_t           retire,
	output frsa_pkg::grant_t            grant
);
	import frsa_pkg::*;

	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] tail_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] tail_nxt;
	logic             queue_full;

	assign queue_full = ({4'd0, queue_count} >= 9'(MAX_SLOTS));

	// Grant from the tail; wrap to slot 0 once the tail has hit the ring size,
	// but only if the head has already moved past slot 0.
	always_comb begin
		grant.ok   = 1'b0;
		grant.slot = '0;
		tail_nxt   = tail_q;
		if (used_q < size && !queue_full) begin
			if (tail_q >= head_q) begin
				if (tail_q < size) begin
					grant.ok   = 1'b1;
					grant.slot = tail_q;
					tail_nxt   = tail_q + 1'b1;
				end else if (head_q != '0) begin
					grant.ok   = 1'b1;
					grant.slot = '0;
					tail_nxt   = CNT_W'(1);
				end
			end else begin
				grant.ok   = 1'b1;
				grant.slot = tail_q;
				tail_nxt   = tail_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
		end else if (clr) begin
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
		end else if (push && grant.ok) begin
			tail_q <= tail_nxt;
			used_q <= used_q + 1'b1;
		end else if (retire.valid) begin
			head_q <= retire.slot + 1'b1;
			if (used_q != '0) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/fence_tracked_ring_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// fence_tracked_ring_slot_allocator_unit: ring slot allocator with fence retire
// Hands out frame slots from a ring and retires them in order once the
// reported completed fence has reached each frame's expected fence.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                       Direction
//  --------  --------------------------------------------  ---------
//  in        in_valid, in_ready, action, fence_value        input item
//  out       out_valid, out_ready, kind, slot_index, last   result item
//  cfg       cfg_we, cfg_wdata (ring_slots)                 register write
//
// A push item has its slot decision made from the pointer registers in the
// accept cycle, and the result lands in the output register. A completion
// item moves the unit into its retire state, which retires frames from the
// front one by one: the queue is a chain of cells that shifts toward the
// front once per retirement, and a completion that retires nothing still
// passes through the retire state before the next item is taken.
// Reset is asynchronous and needs no clearing pass; queue cells are only read
// below the queue count. A stalled output holds its result and blocks further
// retirements and new items until it is taken.
//
module fence_tracked_ring_slot_allocator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frsa_pkg::CNT_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [frsa_pkg::FENCE_W-1:0]    fence_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [frsa_pkg::KIND_W-1:0]     kind,
	output logic [frsa_pkg::IDX_W-1:0]      slot_index,
	output logic                            last
);
	import frsa_pkg::*;

	// Reset ring size is 16, limited to what the queue can hold.
	localparam logic [CNT_W-1:0] RESET_SLOTS = (MAX_SLOTS < 16) ? CNT_W'(MAX_SLOTS) : 5'd16;

	state_t           st_q;
	logic [CNT_W-1:0] size_q;
	logic [CNT_W-1:0] count_q;
	logic [N_W-1:0]   n_q;
	logic [FENCE_W-1:0] comp_fence_q;

	logic             out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [IDX_W-1:0] slot_q;
	logic             last_q;

	logic             out_free;
	logic             accept;
	logic             push;
	logic             comp;
	logic             head_ok;
	logic             next_ok;
	logic             last_emit;
	logic             emit;
	logic [CNT_W-1:0] size_wr;

	grant_t           grant;
	retire_t          retire;

	logic [FENCE_W-1:0] cell_fence [MAX_SLOTS];
	logic [CNT_W-1:0]   cell_slot  [MAX_SLOTS];

	// The output register is free when empty or when its item leaves now.
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (st_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign push     = accept && !action;
	assign comp     = accept && action;

	// The front frame retires when its fence has been reached and the per-item
	// cap is not yet used up. Looking one cell further tells whether this
	// retirement is the final result of the completion item.
	assign head_ok   = (count_q != '0) && (cell_fence[0] <= comp_fence_q) &&
	                   (n_q != N_W'(RESULT_CAP));
	assign next_ok   = (count_q > CNT_W'(1)) && (cell_fence[1] <= comp_fence_q);
	assign last_emit = !next_ok || (n_q == N_W'(RESULT_CAP - 1));
	assign emit      = (st_q == ST_RETIRE) && head_ok && out_free;

	assign retire.valid = emit;
	assign retire.slot  = cell_slot[0];

	// Out-of-range ring sizes are clamped to 1..MAX_SLOTS.
	always_comb begin
		size_wr = cfg_wdata;
		if (cfg_wdata == '0) begin
			size_wr = CNT_W'(1);
		end else if ({4'd0, cfg_wdata} > 9'(MAX_SLOTS)) begin
			size_wr = CNT_W'(MAX_SLOTS);
		end
	end

	frsa_alloc u_alloc (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (cfg_we),
		.size        (size_q),
		.queue_count (count_q),
		.push        (push),
		.retire      (retire),
		.grant       (grant)
	);

	// Queue of frames in flight: cell 0 is the front. A granted push loads the
	// cell just past the last occupied one; a retirement shifts every cell
	// down by one.
	genvar gi;
	generate
		for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
			cell_ctl_t          ctl;
			logic [FENCE_W-1:0] nb_fence;
			logic [CNT_W-1:0]   nb_slot;

			assign ctl.load  = push && grant.ok && ({4'd0, count_q} == 9'(gi));
			assign ctl.shift = emit;

			if (gi == MAX_SLOTS - 1) begin : g_top
				assign nb_fence = '0;
				assign nb_slot  = '0;
			end else begin : g_mid
				assign nb_fence = cell_fence[gi+1];
				assign nb_slot  = cell_slot[gi+1];
			end

			frsa_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.load_fence (fence_value),
				.load_slot  (grant.slot),
				.next_fence (nb_fence),
				.next_slot  (nb_slot),
				.fence      (cell_fence[gi]),
				.slot       (cell_slot[gi])
			);
		end
	endgenerate

	// Control: state, ring size, queue count and retirement count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			size_q  <= RESET_SLOTS;
			count_q <= '0;
			n_q     <= '0;
		end else if (cfg_we) begin
			// A ring size write also empties the ring.
			st_q    <= ST_IDLE;
			size_q  <= size_wr;
			count_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (push && grant.ok) begin
						count_q <= count_q + 1'b1;
					end
					if (comp) begin
						n_q  <= '0;
						st_q <= ST_RETIRE;
					end
				end
				ST_RETIRE: begin
					if (!head_ok) begin
						st_q <= ST_IDLE;
					end else if (emit) begin
						count_q <= count_q - 1'b1;
						n_q     <= n_q + 1'b1;
						if (last_emit) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (comp) begin
			comp_fence_q <= fence_value;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push || emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q <= grant.ok ? KIND_ALLOC : KIND_FULL;
			slot_q <= grant.ok ? grant.slot[IDX_W-1:0] : '0;
			last_q <= 1'b1;
		end else if (emit) begin
			kind_q <= KIND_FREED;
			slot_q <= cell_slot[0][IDX_W-1:0];
			last_q <= last_emit;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign slot_index = slot_q;
	assign last       = last_q;

endmodule

FILE: src/frsa_checker.sv
// ----------------------------------------------------------------------------
// frsa_checker: port-level checks for the ring slot allocator
// Watches the top level's ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
module frsa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [frsa_pkg::KIND_W-1:0] kind,
	input logic [frsa_pkg::IDX_W-1:0]  slot_index,
	input logic                        last
);
	import frsa_pkg::*;

	// A stalled result holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(slot_index) &&
		$stable(last))
		else $error("stalled result changed");

	// Only the three defined result codes appear.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_ALLOC) || (kind == KIND_FULL) || (kind == KIND_FREED))
		else $error("undefined result code");

	// A refused push reports slot 0 and is the item's only result.
	a_full_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FULL |-> slot_index == '0 && last)
		else $error("refused push result malformed");

	// A push gives exactly one result, so it is always marked last.
	a_alloc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ALLOC |-> last)
		else $error("allocation result not marked last");

	// No new item is taken while a result waits in the output register.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted behind a stalled result");

endmodule

bind fence_tracked_ring_slot_allocator_unit frsa_checker u_frsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.slot_index (slot_index),
	.last       (last)
);
